// ===== design/zzrr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// zzrr_pkg
// shared types and constants for the zigzag row reorder block
// ---------------------------------------------------------------------------
package zzrr_pkg;

    localparam int CHAR_W     = 8;
    localparam int ROWS_W     = 7;
    localparam int DIST_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [0:0] REG_NUM_ROWS = 1'b0;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEEK,
        ST_OUT
    } zzrr_state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic fetch;
        logic clear;
    } zzrr_cmd_t;

    typedef struct packed {
        logic load_done;
        logic cand_valid;
        logic out_is_last;
    } zzrr_status_t;

endpackage
`default_nettype wire

// ===== design/zzrr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// zzrr_datapath
// message store, fill count, zigzag cursor and output register
// ---------------------------------------------------------------------------
module zzrr_datapath #(
    parameter int MAX_LEN = 64
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire zzrr_pkg::zzrr_cmd_t         cmd,
    output      zzrr_pkg::zzrr_status_t      status,
    input  wire logic [zzrr_pkg::ROWS_W-1:0] num_rows,
    input  wire logic [zzrr_pkg::CHAR_W-1:0] in_char,
    input  wire logic                        in_last,
    output      logic [zzrr_pkg::CHAR_W-1:0] out_char,
    output      logic                        out_last
);

    localparam int AW    = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int PW    = $clog2(MAX_LEN + 256);

    logic [zzrr_pkg::CHAR_W-1:0] mem [MAX_LEN];

    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            emitted_reg, emitted_next;
    logic [zzrr_pkg::ROWS_W-1:0] row_reg, row_next;
    logic [PW-1:0]               pos_reg, pos_next;
    logic [zzrr_pkg::DIST_W-1:0] dm_reg, dm_next;
    logic                        phase_reg, phase_next;
    logic [zzrr_pkg::CHAR_W-1:0] char_reg;
    logic                        last_reg;

    logic                        multi;
    logic [zzrr_pkg::DIST_W-1:0] period;
    logic                        middle;
    logic [PW-1:0]               cand_addr;
    logic [PW-1:0]               count_ext;
    logic                        cand_valid;

    assign multi     = num_rows > zzrr_pkg::ROWS_W'(1);
    assign period    = multi ? ({num_rows, 1'b0} - zzrr_pkg::DIST_W'(2))
                             : zzrr_pkg::DIST_W'(1);
    assign middle    = multi && (row_reg != '0)
                       && (row_reg != num_rows - zzrr_pkg::ROWS_W'(1));
    assign cand_addr = phase_reg ? (pos_reg + PW'(dm_reg)) : pos_reg;
    assign count_ext = PW'(count_reg);
    assign cand_valid = cand_addr < count_ext;

    assign status.load_done   = in_last || (count_reg == CNT_W'(MAX_LEN - 1));
    assign status.cand_valid  = cand_valid;
    assign status.out_is_last = last_reg;

    assign out_char = char_reg;
    assign out_last = last_reg;

    always_comb begin
        count_next   = count_reg;
        emitted_next = emitted_reg;
        row_next     = row_reg;
        pos_next     = pos_reg;
        dm_next      = dm_reg;
        phase_next   = phase_reg;
        if (cmd.load) begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.clear) begin
            count_next = '0;
        end
        if (cmd.start) begin
            emitted_next = '0;
            row_next     = '0;
            pos_next     = '0;
            dm_next      = period;
            phase_next   = 1'b0;
        end else if (cmd.step) begin
            if (phase_reg) begin
                phase_next = 1'b0;
                pos_next   = pos_reg + PW'(period);
            end else if (cand_valid) begin
                if (middle) begin
                    phase_next = 1'b1;
                end else begin
                    pos_next = pos_reg + PW'(period);
                end
            end else begin
                row_next = row_reg + zzrr_pkg::ROWS_W'(1);
                pos_next = PW'(row_reg) + PW'(1);
                dm_next  = dm_reg - zzrr_pkg::DIST_W'(2);
            end
            if (cmd.fetch) begin
                emitted_next = emitted_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            emitted_reg <= '0;
            row_reg     <= '0;
            pos_reg     <= '0;
            dm_reg      <= '0;
            phase_reg   <= 1'b0;
        end else begin
            count_reg   <= count_next;
            emitted_reg <= emitted_next;
            row_reg     <= row_next;
            pos_reg     <= pos_next;
            dm_reg      <= dm_next;
            phase_reg   <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mem[count_reg[AW-1:0]] <= in_char;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            char_reg <= mem[cand_addr[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= 1'b0;
        end else if (cmd.fetch) begin
            last_reg <= (emitted_reg + CNT_W'(1)) == count_reg;
        end
    end

endmodule
`default_nettype wire

// ===== design/zzrr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// zzrr_ctrl
// sequencer for message load, cursor walk and result transfers
// ---------------------------------------------------------------------------
module zzrr_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output      logic                   in_ready,
    output      logic                   out_valid,
    input  wire logic                   out_ready,
    input  wire zzrr_pkg::zzrr_status_t status,
    output      zzrr_pkg::zzrr_cmd_t    cmd
);

    zzrr_pkg::zzrr_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            zzrr_pkg::ST_LOAD: begin
                if (in_valid && status.load_done) begin
                    state_next = zzrr_pkg::ST_SEEK;
                end
            end
            zzrr_pkg::ST_SEEK: begin
                if (status.cand_valid) begin
                    state_next = zzrr_pkg::ST_OUT;
                end
            end
            zzrr_pkg::ST_OUT: begin
                if (out_ready) begin
                    if (status.out_is_last) begin
                        state_next = zzrr_pkg::ST_LOAD;
                    end else if (!status.cand_valid) begin
                        state_next = zzrr_pkg::ST_SEEK;
                    end
                end
            end
            default: state_next = zzrr_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            zzrr_pkg::ST_LOAD: begin
                in_ready  = 1'b1;
                cmd.load  = in_valid;
                cmd.start = in_valid && status.load_done;
            end
            zzrr_pkg::ST_SEEK: begin
                cmd.step  = 1'b1;
                cmd.fetch = status.cand_valid;
            end
            zzrr_pkg::ST_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    if (status.out_is_last) begin
                        cmd.clear = 1'b1;
                    end else begin
                        cmd.step  = 1'b1;
                        cmd.fetch = status.cand_valid;
                    end
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= zzrr_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/zigzag_row_reorder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// zigzag_row_reorder
// buffers a byte message and replays it in rail-fence row order
// ---------------------------------------------------------------------------
//  channel   direction  signals
//  s_        in         s_valid s_ready s_in_char s_in_last
//  m_        out        m_valid m_ready m_out_char m_out_last
//  apb       in/out     psel penable pwrite paddr pwdata prdata pready
//
//  load takes one cycle per byte; a message ends on last or a full store
//  replay starts in the seek state after the final load, then gives one byte
//  per cycle while m_ready holds, except where the single cursor walk
//  changes row or skips a row partner, which passes through the seek state
//  s_ready stays low from the final load until the last byte transfers
//  m_ready low with m_valid high holds the output register and the cursor
//  aresetn clears count, cursor and state; num_rows resets to one
// ---------------------------------------------------------------------------
module zigzag_row_reorder #(
    parameter int MAX_LEN = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output      logic                            s_ready,
    input  wire logic [zzrr_pkg::CHAR_W-1:0]     s_in_char,
    input  wire logic                            s_in_last,
    output      logic                            m_valid,
    input  wire logic                            m_ready,
    output      logic [zzrr_pkg::CHAR_W-1:0]     m_out_char,
    output      logic                            m_out_last,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [zzrr_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [zzrr_pkg::CFG_DATA_W-1:0] pwdata,
    output      logic [zzrr_pkg::CFG_DATA_W-1:0] prdata,
    output      logic                            pready
);

    logic [zzrr_pkg::ROWS_W-1:0] num_rows_reg;
    logic                        sel_num_rows;
    zzrr_pkg::zzrr_cmd_t         cmd;
    zzrr_pkg::zzrr_status_t      status;

    assign pready       = 1'b1;
    assign sel_num_rows = paddr[zzrr_pkg::CFG_ADDR_W-1] == zzrr_pkg::REG_NUM_ROWS;
    assign prdata       = sel_num_rows ? zzrr_pkg::CFG_DATA_W'(num_rows_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg <= zzrr_pkg::ROWS_W'(1);
        end else if (psel && penable && pwrite && sel_num_rows) begin
            num_rows_reg <= pwdata[zzrr_pkg::ROWS_W-1:0];
        end
    end

    zzrr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .status    (status),
        .cmd       (cmd)
    );

    zzrr_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .num_rows (num_rows_reg),
        .in_char  (s_in_char),
        .in_last  (s_in_last),
        .out_char (m_out_char),
        .out_last (m_out_last)
    );

endmodule
`default_nettype wire

// ===== sim/tb_zigzag_row_reorder.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_zigzag_row_reorder
// self-checking bench for the rail-fence byte reorder block: random messages
// under several row counts, burst gaps on the input, stalls on the output,
// and every output transfer compared against a built-in zigzag predictor
// ---------------------------------------------------------------------------
module tb_zigzag_row_reorder;

    localparam int MSG_MAX     = 64;
    localparam int IDLE_CYCLES = 300;
    localparam int ITEM_TARGET = 450;
    localparam logic [zzrr_pkg::CFG_ADDR_W-1:0] ROWS_ADDR = {zzrr_pkg::REG_NUM_ROWS, 2'b00};

    typedef struct packed {
        logic [zzrr_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } out_byte_t;

    class zigzag_checker;
        logic [zzrr_pkg::CHAR_W-1:0] msg_buf[MSG_MAX];
        int                          held;
        logic [zzrr_pkg::ROWS_W-1:0] rows;
        out_byte_t                   expected_bytes[$];
        int                          mismatches;

        function new();
            held       = 0;
            rows       = zzrr_pkg::ROWS_W'(1);
            mismatches = 0;
        endfunction

        function void set_rows(logic [zzrr_pkg::ROWS_W-1:0] r);
            rows = r;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void reorder_message();
            logic [zzrr_pkg::CHAR_W-1:0] order[$];
            int                          period;
            int                          mate;
            out_byte_t                   ob;
            if (rows <= 1) begin
                for (int p = 0; p < held; p++) order.push_back(msg_buf[p]);
            end else begin
                period = 2 * int'(rows) - 2;
                for (int r = 0; r < int'(rows) && r < held; r++) begin
                    for (int p = r; p < held; p += period) begin
                        order.push_back(msg_buf[p]);
                        if (r != 0 && r != int'(rows) - 1) begin
                            mate = p + period - 2 * r;
                            if (mate < held) order.push_back(msg_buf[mate]);
                        end
                    end
                end
            end
            foreach (order[i]) begin
                ob.ch   = order[i];
                ob.last = (i == order.size() - 1);
                expected_bytes.push_back(ob);
            end
            held = 0;
        endfunction

        function void take_byte(logic [zzrr_pkg::CHAR_W-1:0] ch, logic last);
            if (held < MSG_MAX) begin
                msg_buf[held] = ch;
                held++;
            end
            if (last || held >= MSG_MAX) reorder_message();
        endfunction

        function void check_byte(logic [zzrr_pkg::CHAR_W-1:0] ch, logic last);
            out_byte_t want;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected transfer, actual char %02h last %0b",
                         $time, ch, last);
                return;
            end
            want = expected_bytes.pop_front();
            if (want.ch !== ch) begin
                mismatches++;
                $display("%0t: out_char expected %02h actual %02h", $time, want.ch, ch);
            end
            if (want.last !== last) begin
                mismatches++;
                $display("%0t: out_last expected %0b actual %0b", $time, want.last, last);
            end
        endfunction
    endclass

    logic                              aclk       = 1'b0;
    logic                              aresetn    = 1'b0;
    logic                              s_valid    = 1'b0;
    logic                              s_ready;
    logic [zzrr_pkg::CHAR_W-1:0]       s_in_char  = '0;
    logic                              s_in_last  = 1'b0;
    logic                              m_valid;
    logic                              m_ready    = 1'b0;
    logic [zzrr_pkg::CHAR_W-1:0]       m_out_char;
    logic                              m_out_last;
    logic                              psel       = 1'b0;
    logic                              penable    = 1'b0;
    logic                              pwrite     = 1'b0;
    logic [zzrr_pkg::CFG_ADDR_W-1:0]   paddr      = '0;
    logic [zzrr_pkg::CFG_DATA_W-1:0]   pwdata     = '0;
    logic [zzrr_pkg::CFG_DATA_W-1:0]   prdata;
    logic                              pready;

    zigzag_checker sb;
    int            items_sent  = 0;
    int            burst_left  = 0;
    bit            gaps_on     = 1'b1;
    int            rx_mode     = 0;
    int            rx_mode_left = 0;
    int            rx_hold     = 0;
    bit            rx_low      = 1'b0;

    zigzag_row_reorder #(.MAX_LEN(MSG_MAX)) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_char  (s_in_char),
        .s_in_last  (s_in_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_out_last (m_out_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("zigzag_row_reorder: mismatch");
        $finish;
    end

    // one monitor for both channels so input and output order is fixed
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.take_byte(s_in_char, s_in_last);
            if (m_valid && m_ready) sb.check_byte(m_out_char, m_out_last);
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(20, 120);
            end
            rx_mode_left--;
            case (rx_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= ($urandom_range(0, 9) < 7);
                end
                default: begin
                    if (rx_hold == 0) begin
                        rx_low  = !rx_low;
                        rx_hold = rx_low ? $urandom_range(1, 16) : $urandom_range(1, 8);
                    end
                    rx_hold--;
                    m_ready <= !rx_low;
                end
            endcase
        end
    end

    task automatic write_rows(input logic [zzrr_pkg::ROWS_W-1:0] r);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ROWS_ADDR;
        pwdata  <= zzrr_pkg::CFG_DATA_W'(r);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_rows(r);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[zzrr_pkg::ROWS_W-1:0] !== r) begin
            sb.mismatches++;
            $display("%0t: num_rows readback expected %0d actual %0d",
                     $time, r, prdata[zzrr_pkg::ROWS_W-1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_byte(input logic [zzrr_pkg::CHAR_W-1:0] ch, input logic last);
        if (gaps_on && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        s_valid   <= 1'b1;
        s_in_char <= ch;
        s_in_last <= last;
        do @(posedge aclk); while (!s_ready);
        if (burst_left > 0) burst_left--;
        items_sent++;
    endtask

    task automatic send_message(input int len);
        logic last;
        for (int i = 0; i < len; i++) begin
            last = (i == len - 1);
            // a message ending on a full store may or may not carry last
            if (last && len % MSG_MAX == 0) last = 1'($urandom_range(0, 1));
            send_byte(zzrr_pkg::CHAR_W'($urandom_range(0, 255)), last);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (IDLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_walk(input int len, input logic [zzrr_pkg::CHAR_W-1:0] first);
        for (int i = 0; i < len; i++) begin
            send_byte(first + zzrr_pkg::CHAR_W'(i), i == len - 1);
        end
    endtask

    initial begin
        int                          phase;
        int                          pick;
        int                          len;
        logic [zzrr_pkg::ROWS_W-1:0] r;
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset row count, then zero, few, max and many rows
        gaps_on = 1'b0;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
        wait_idle();
        write_rows(7'd0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        wait_idle();
        write_rows(7'd2);
        send_byte(8'hA5, 1'b1);
        wait_idle();
        write_rows(7'd3);
        send_walk(7, 8'h10);
        wait_idle();
        write_rows(7'd127);
        send_walk(3, 8'hF0);
        wait_idle();
        write_rows(7'd64);
        send_walk(4, 8'hC0);
        wait_idle();

        // random phases, extreme row counts first
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase)
                0: r = 7'd0;
                1: r = 7'd127;
                2: r = 7'd64;
                3: r = 7'd2;
                4: r = 7'd1;
                default: begin
                    pick = $urandom_range(0, 3);
                    if (pick < 2) r = zzrr_pkg::ROWS_W'($urandom_range(2, 8));
                    else if (pick == 2) r = zzrr_pkg::ROWS_W'($urandom_range(1, 64));
                    else r = zzrr_pkg::ROWS_W'($urandom_range(0, 127));
                end
            endcase
            write_rows(r);
            gaps_on    = ($urandom_range(0, 3) != 0);
            burst_left = 0;
            repeat ($urandom_range(2, 6)) begin
                pick = $urandom_range(0, 19);
                if (pick < 16) len = $urandom_range(1, 12);
                else if (pick < 19) len = $urandom_range(13, 63);
                else len = $urandom_range(0, 1) ? MSG_MAX : $urandom_range(65, 2 * MSG_MAX);
                send_message(len);
            end
            wait_idle();
            phase++;
        end

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("zigzag_row_reorder: match");
        end else begin
            $display("zigzag_row_reorder: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/zzrr_pkg.sv
design/zzrr_datapath.sv
design/zzrr_ctrl.sv
design/zigzag_row_reorder.sv
sim/tb_zigzag_row_reorder.sv
